>>> src/missing_tooth_trigger_sync_unit_assert.svh
// Assertion macros for the missing-tooth trigger sync unit.
// Both expect signals named clk and rst in the module that uses them.
`ifndef MISSING_TOOTH_TRIGGER_SYNC_UNIT_ASSERT_SVH
`define MISSING_TOOTH_TRIGGER_SYNC_UNIT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MTTS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MTTS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/mtts_pkg.sv
`timescale 1ns / 1ps

package mtts_pkg;

  // Table geometry: one entry per tooth of a segment.
  localparam int SEG_TEETH = 60;
  localparam int IDX_W     = $clog2(SEG_TEETH);
  localparam int STAMP_W   = 16;

  // Result queue geometry.
  localparam int RES_DEPTH = 2;
  localparam int RES_PTR_W = $clog2(RES_DEPTH);
  localparam int RES_CNT_W = $clog2(RES_DEPTH + 1);

  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [IDX_W-1:0]   idx_t;

  // Value of every period register after reset, and of a table entry that is not valid.
  localparam stamp_t PERIOD_INIT = '1;

  // Input item opcodes.
  localparam logic OP_EDGE    = 1'b0;
  localparam logic OP_TIMEOUT = 1'b1;

  // Outcome of the end-of-segment pattern check.
  typedef enum logic [1:0] {
    CHK_NONE   = 2'd0,
    CHK_OK     = 2'd1,
    CHK_MISSED = 2'd2,
    CHK_EXTRA  = 2'd3
  } chk_t;

  // Work left for the second stage after the memory read.
  typedef enum logic [1:0] {
    BOP_IDLE,
    BOP_COPY,
    BOP_CHECK
  } bop_t;

  // One result item.
  typedef struct packed {
    logic armed;
    logic gap_seen;
    chk_t check_result;
    logic stopped;
  } res_t;

endpackage

>>> src/mtts_res_fifo.sv
`timescale 1ns / 1ps

module mtts_res_fifo
  import mtts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_item,
  output logic full,
  output logic out_valid,
  input  logic out_stall,
  output res_t out_item
);

  res_t                 slot [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 pop;

  // Status and head of the queue.
  assign out_valid = (count != '0);
  assign full      = (count == RES_CNT_W'(RES_DEPTH));
  assign pop       = out_valid && !out_stall;
  assign out_item  = slot[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= RES_PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= RES_PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= RES_CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= RES_CNT_W'(count - 1'b1);
      end
    end
  end

  // Result storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule

>>> src/missing_tooth_trigger_sync_unit.sv
// Missing-tooth trigger sync unit: tooth periods are kept in a 60-entry table memory.
// Results: an accepted item pushes its result into the result queue at once, a resync edge
// included; the result of a segment-end pattern check is pushed by the second stage.
// Throughput: one item per cycle while the result queue is not full; a resync or check edge
// holds the input while its table read completes and the copy or check uses the read data.
// Reset: synchronous; entry valid bits clear at once, so no clearing pass is needed.
`timescale 1ns / 1ps

`include "missing_tooth_trigger_sync_unit_assert.svh"

module missing_tooth_trigger_sync_unit
  import mtts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 opcode,
  input  logic [STAMP_W-1:0]   edge_stamp,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 armed,
  output logic                 gap_seen,
  output logic [1:0]           check_result,
  output logic                 stopped
);

  localparam idx_t IDX_ONE  = IDX_W'(1);
  localparam idx_t IDX_TWO  = IDX_W'(2);
  localparam idx_t IDX_LAST = IDX_W'(SEG_TEETH - 1);
  localparam idx_t IDX_CHKA = IDX_W'(SEG_TEETH - 3);
  localparam idx_t IDX_CHKB = IDX_W'(SEG_TEETH - 2);

  // Scalar state.
  logic   running,     running_next;
  stamp_t last_stamp,  last_stamp_next;
  stamp_t p_new,       p_new_next;
  stamp_t p_mid,       p_mid_next;
  stamp_t p_old,       p_old_next;
  logic   gap_latched, gap_latched_next;
  idx_t   write_index, write_index_next;

  // Tooth table and its valid bits.
  stamp_t                 mem [SEG_TEETH];
  logic [SEG_TEETH-1:0]   ent_valid;
  stamp_t                 rd_data0, rd_data1;
  logic                   rd_vld0, rd_vld1;

  // Second stage.
  bop_t   b_op, b_op_next;
  logic   b_gap;
  stamp_t b_period;

  // First stage signals.
  logic   in_acc;
  idx_t   idx;
  stamp_t period;
  stamp_t half_mid;
  logic   gap;
  logic   a_reinit;
  logic   a_wr_en;
  idx_t   a_wr_addr;
  logic   rd_en;
  idx_t   rd_addr0;
  logic   push_a;
  res_t   res_a;

  // Second stage signals.
  stamp_t ent_a, ent_b;
  chk_t   b_chk;
  logic   b_stop;
  logic   push_b;
  res_t   res_b;

  // Memory write port.
  logic   wr_en;
  idx_t   wr_addr;
  stamp_t wr_data;
  logic   wr_vld;

  // Result queue.
  logic   push;
  res_t   push_item;
  logic   res_full;
  res_t   out_item;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (b_op != BOP_IDLE) || res_full;

  // Window arithmetic for an edge while running.
  always_comb begin
    if (write_index == '0 || write_index > IDX_LAST) begin
      idx = IDX_ONE;
    end else begin
      idx = write_index;
    end
    period   = edge_stamp - last_stamp;
    half_mid = p_new >> 1;
    gap      = (half_mid > period) && (half_mid > p_mid);
  end

  // First stage: window update, table write and read issue.
  always_comb begin
    running_next     = running;
    last_stamp_next  = last_stamp;
    p_new_next       = p_new;
    p_mid_next       = p_mid;
    p_old_next       = p_old;
    gap_latched_next = gap_latched;
    write_index_next = write_index;
    a_reinit         = 1'b0;
    a_wr_en          = 1'b0;
    a_wr_addr        = idx;
    rd_en            = 1'b0;
    rd_addr0         = IDX_CHKA;
    b_op_next        = BOP_IDLE;
    push_a           = 1'b0;
    res_a            = '0;
    if (in_acc) begin
      push_a = 1'b1;
      if (opcode == OP_TIMEOUT) begin
        a_reinit      = 1'b1;
        res_a.stopped = 1'b1;
      end else if (!running) begin
        running_next    = 1'b1;
        last_stamp_next = edge_stamp;
        res_a.armed     = 1'b1;
      end else begin
        last_stamp_next = edge_stamp;
        p_old_next      = p_mid;
        p_mid_next      = p_new;
        p_new_next      = period;
        res_a.gap_seen  = gap;
        a_wr_en         = 1'b1;
        if (gap && !gap_latched) begin
          // First gap: restart the table at slot 1, the previous entry moves to slot 0.
          gap_latched_next = 1'b1;
          a_wr_addr        = IDX_ONE;
          rd_en            = 1'b1;
          rd_addr0         = idx - IDX_ONE;
          b_op_next        = BOP_COPY;
          write_index_next = IDX_TWO;
        end else if (idx == IDX_LAST) begin
          write_index_next = IDX_ONE;
          if (gap_latched) begin
            gap_latched_next = 1'b0;
            rd_en            = 1'b1;
            b_op_next        = BOP_CHECK;
            push_a           = 1'b0;
          end else begin
            a_reinit      = 1'b1;
            res_a.stopped = 1'b1;
          end
        end else begin
          write_index_next = idx + IDX_ONE;
        end
      end
    end
  end

  // Second stage: pattern check on the last three entries of the segment.
  always_comb begin
    ent_a  = rd_vld0 ? rd_data0 : PERIOD_INIT;
    ent_b  = rd_vld1 ? rd_data1 : PERIOD_INIT;
    b_chk  = CHK_NONE;
    if ((ent_a >> 1) > ent_b) begin
      b_chk = CHK_MISSED;
    end else if ((ent_b >> 1) > ent_a && (ent_b >> 1) > b_period) begin
      b_chk = CHK_OK;
    end else if ((b_period >> 1) > ent_b) begin
      b_chk = CHK_EXTRA;
    end
    push_b             = (b_op == BOP_CHECK);
    b_stop             = push_b && (b_chk == CHK_NONE);
    res_b              = '0;
    res_b.gap_seen     = b_gap;
    res_b.check_result = b_chk;
    res_b.stopped      = (b_chk == CHK_NONE);
  end

  // Single table write port: the slot-0 copy only happens while the input is held.
  always_comb begin
    if (b_op == BOP_COPY) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = rd_data0;
      wr_vld  = rd_vld0;
    end else begin
      wr_en   = a_wr_en;
      wr_addr = a_wr_addr;
      wr_data = period;
      wr_vld  = 1'b1;
    end
  end

  // Scalar state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      b_op        <= BOP_IDLE;
      running     <= 1'b0;
      last_stamp  <= '0;
      p_new       <= PERIOD_INIT;
      p_mid       <= PERIOD_INIT;
      p_old       <= PERIOD_INIT;
      gap_latched <= 1'b0;
      write_index <= IDX_ONE;
    end else begin
      b_op <= b_op_next;
      if (a_reinit || b_stop) begin
        running     <= 1'b0;
        last_stamp  <= '0;
        p_new       <= PERIOD_INIT;
        p_mid       <= PERIOD_INIT;
        p_old       <= PERIOD_INIT;
        gap_latched <= 1'b0;
        write_index <= IDX_ONE;
      end else begin
        running     <= running_next;
        last_stamp  <= last_stamp_next;
        p_new       <= p_new_next;
        p_mid       <= p_mid_next;
        p_old       <= p_old_next;
        gap_latched <= gap_latched_next;
        write_index <= write_index_next;
      end
    end
  end

  // Entry valid bits: an entry that is not valid reads as all ones.
  always_ff @(posedge clk) begin
    if (rst || a_reinit || b_stop) begin
      ent_valid <= '0;
    end else if (wr_en) begin
      ent_valid[wr_addr] <= wr_vld;
    end
  end

  // Table memory with registered reads.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data0 <= mem[rd_addr0];
      rd_vld0  <= ent_valid[rd_addr0];
      rd_data1 <= mem[IDX_CHKB];
      rd_vld1  <= ent_valid[IDX_CHKB];
    end
  end

  // Values the second stage needs besides the read data.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_gap    <= gap;
      b_period <= period;
    end
  end

  assign push      = push_a || push_b;
  assign push_item = push_b ? res_b : res_a;

  mtts_res_fifo u_res_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (res_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

  assign armed        = out_item.armed;
  assign gap_seen     = out_item.gap_seen;
  assign check_result = out_item.check_result;
  assign stopped      = out_item.stopped;

  // The table read completes before another item may touch the state.
  `MTTS_ASSERT_NOW(a_no_accept_busy, b_op != BOP_IDLE, !in_acc, "item accepted during copy or check")
  `MTTS_ASSERT_NEXT(a_stage_b_once, b_op != BOP_IDLE, b_op == BOP_IDLE, "second stage held over a cycle")
  `MTTS_ASSERT_NOW(a_res_no_overflow, res_full, !push, "result queue overflow")
  `MTTS_ASSERT_NEXT(a_timeout_reinit, in_acc && opcode == OP_TIMEOUT,
                    !running && write_index == IDX_ONE, "timeout did not reinitialize")
  `MTTS_ASSERT_NOW(a_index_range, 1'b1, write_index != '0 && write_index <= IDX_LAST,
                   "write index out of range")

endmodule
